// File: rtl/mpct_pkg.sv
// Package for the mouse packet cursor tracker: payload structs, internal
// control structs, sequencer state type and shared constants.
// No dependencies.
package mpct_pkg;

   localparam int DEF_SCREEN_COLUMNS = 80;
   localparam int DEF_SCREEN_ROWS    = 25;

   localparam int CURSOR_RESET_X = 40;
   localparam int CURSOR_RESET_Y = 12;

   localparam int BYTE_W   = 8;
   localparam int OUT_X_W  = 7;
   localparam int OUT_Y_W  = 5;
   localparam int BTN_W    = 3;

   // Remainder unit: one quotient bit per step
   localparam int MOD_STEPS = BYTE_W;

   localparam logic [BYTE_W-1:0] SENSITIVITY_RESET = 8'd3;

   // Byte positions inside a packet
   localparam logic [1:0] PKT_HEAD_BYTE = 2'd0;
   localparam logic [1:0] PKT_X_BYTE    = 2'd1;
   localparam logic [1:0] PKT_LAST_BYTE = 2'd2;

   // Head byte bit positions
   localparam int HEAD_Y_OVF  = 7;
   localparam int HEAD_X_OVF  = 6;
   localparam int HEAD_Y_SIGN = 5;
   localparam int HEAD_X_SIGN = 4;

   typedef enum logic [1:0] {
      ST_COLLECT,
      ST_MOD_X,
      ST_MOD_Y,
      ST_COMMIT
   } seq_state_type;

   typedef struct packed {
      logic [BYTE_W-1:0] data_byte;
   } req_payload_type;

   typedef struct packed {
      logic [BYTE_W-1:0] sensitivity;
   } csr_payload_type;

   typedef struct packed {
      logic               packet_dropped;
      logic [OUT_X_W-1:0] cursor_x;
      logic [OUT_Y_W-1:0] cursor_y;
      logic [OUT_X_W-1:0] previous_x;
      logic [OUT_Y_W-1:0] previous_y;
      logic               left_pressed;
      logic               right_pressed;
      logic               middle_pressed;
      logic [BTN_W-1:0]   buttons_held;
   } rsp_payload_type;

   typedef struct packed {
      logic              start;
      logic [BYTE_W-1:0] dividend;
   } mod_req_type;

   typedef struct packed {
      logic              done;
      logic [BYTE_W-1:0] remainder;
   } mod_rsp_type;

   typedef struct packed {
      logic              commit;
      logic [BYTE_W-1:0] head;
      logic [BYTE_W-1:0] dx;
      logic [BYTE_W-1:0] dy;
   } upd_type;

endpackage

// File: rtl/mpct_chan_if.sv
// Valid/ready channel interface used for the byte input, the result output
// and the sensitivity write port. Payload type is a parameter.
interface mpct_chan_if #(parameter type payload_type = logic [7:0]) ();
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

// File: rtl/mpct_mod_unit.sv
// Iterative restoring remainder unit, one bit per cycle.
// Depends on mpct_pkg.
module mpct_mod_unit
   import mpct_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  mod_req_type       mod_req,
   input  logic [BYTE_W-1:0] divisor,
   output mod_rsp_type       mod_rsp
);

   localparam int CNT_W = $clog2(MOD_STEPS);

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [BYTE_W-1:0] rem_ff, rem_in;
   logic [BYTE_W-1:0] dvd_ff, dvd_in;
   logic [BYTE_W:0]   trial;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      dvd_in  = dvd_ff;
      trial   = {rem_ff, dvd_ff[BYTE_W-1]};
      if (mod_req.start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = '0;
         dvd_in  = mod_req.dividend;
      end else if (busy_ff) begin
         // zero divisor leaves the dividend as remainder
         if (trial >= {1'b0, divisor}) begin
            rem_in = BYTE_W'(trial - {1'b0, divisor});
         end else begin
            rem_in = trial[BYTE_W-1:0];
         end
         dvd_in = {dvd_ff[BYTE_W-2:0], 1'b0};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(MOD_STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      dvd_ff <= dvd_in;
   end

   assign mod_rsp.done      = done_ff;
   assign mod_rsp.remainder = rem_ff;

endmodule

// File: rtl/mpct_cursor.sv
// Cursor position, button flags and result word register.
// Depends on mpct_pkg.
module mpct_cursor
   import mpct_pkg::*;
#(
   parameter int SCREEN_COLUMNS = DEF_SCREEN_COLUMNS,
   parameter int SCREEN_ROWS    = DEF_SCREEN_ROWS
) (
   input  logic            clock,
   input  logic            reset,
   input  upd_type         upd,
   output rsp_payload_type rsp_data
);

   // position registers must hold both the screen range and the reset spot
   localparam int XW  = $clog2(SCREEN_COLUMNS > CURSOR_RESET_X + 1 ?
                               SCREEN_COLUMNS : CURSOR_RESET_X + 1);
   localparam int YW  = $clog2(SCREEN_ROWS > CURSOR_RESET_Y + 1 ?
                               SCREEN_ROWS : CURSOR_RESET_Y + 1);
   localparam int AXW = (XW > BYTE_W ? XW : BYTE_W) + 1;
   localparam int AYW = (YW > BYTE_W ? YW : BYTE_W) + 1;
   localparam int XOW = XW + OUT_X_W;
   localparam int YOW = YW + OUT_Y_W;

   logic [XW-1:0]    pos_x_ff, pos_x_in, prior_x_ff, prior_x_in;
   logic [YW-1:0]    pos_y_ff, pos_y_in, prior_y_ff, prior_y_in;
   logic [BTN_W-1:0] flags_ff, flags_in;
   rsp_payload_type  rsp_ff, rsp_in;

   logic             drop;
   logic [BTN_W-1:0] buttons, presses;
   logic [AXW-1:0]   x_ext, dx_ext, nx;
   logic [AYW-1:0]   y_ext, dy_ext, ny;
   logic             x_ok, y_ok;
   logic [XOW-1:0]   cur_x_w, prv_x_w;
   logic [YOW-1:0]   cur_y_w, prv_y_w;

   always_comb begin
      drop    = upd.head[HEAD_Y_OVF] | upd.head[HEAD_X_OVF];
      buttons = upd.head[BTN_W-1:0];
      presses = buttons & ~flags_ff;

      x_ext  = AXW'(pos_x_ff);
      dx_ext = AXW'(upd.dx);
      y_ext  = AYW'(pos_y_ff);
      dy_ext = AYW'(upd.dy);

      if (upd.head[HEAD_X_SIGN]) begin
         nx   = x_ext - dx_ext;
         x_ok = (dx_ext <= x_ext) && (nx < AXW'(SCREEN_COLUMNS));
      end else begin
         nx   = x_ext + dx_ext;
         x_ok = nx < AXW'(SCREEN_COLUMNS);
      end
      // sign bit set moves down the screen
      if (upd.head[HEAD_Y_SIGN]) begin
         ny   = y_ext + dy_ext;
         y_ok = ny < AYW'(SCREEN_ROWS);
      end else begin
         ny   = y_ext - dy_ext;
         y_ok = (dy_ext <= y_ext) && (ny < AYW'(SCREEN_ROWS));
      end

      pos_x_in   = pos_x_ff;
      pos_y_in   = pos_y_ff;
      prior_x_in = prior_x_ff;
      prior_y_in = prior_y_ff;
      flags_in   = flags_ff;
      if (upd.commit && !drop) begin
         flags_in   = buttons;
         prior_x_in = pos_x_ff;
         prior_y_in = pos_y_ff;
         if (x_ok && y_ok) begin
            pos_x_in = nx[XW-1:0];
            pos_y_in = ny[YW-1:0];
         end
      end

      cur_x_w = XOW'(pos_x_in);
      prv_x_w = XOW'(prior_x_in);
      cur_y_w = YOW'(pos_y_in);
      prv_y_w = YOW'(prior_y_in);

      rsp_in                = rsp_ff;
      if (upd.commit) begin
         rsp_in.packet_dropped = drop;
         rsp_in.cursor_x       = cur_x_w[OUT_X_W-1:0];
         rsp_in.cursor_y       = cur_y_w[OUT_Y_W-1:0];
         rsp_in.previous_x     = prv_x_w[OUT_X_W-1:0];
         rsp_in.previous_y     = prv_y_w[OUT_Y_W-1:0];
         rsp_in.left_pressed   = !drop && presses[0];
         rsp_in.right_pressed  = !drop && presses[1];
         rsp_in.middle_pressed = !drop && presses[2];
         rsp_in.buttons_held   = flags_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_x_ff   <= XW'(CURSOR_RESET_X);
         pos_y_ff   <= YW'(CURSOR_RESET_Y);
         prior_x_ff <= XW'(CURSOR_RESET_X);
         prior_y_ff <= YW'(CURSOR_RESET_Y);
         flags_ff   <= '0;
      end else begin
         pos_x_ff   <= pos_x_in;
         pos_y_ff   <= pos_y_in;
         prior_x_ff <= prior_x_in;
         prior_y_ff <= prior_y_in;
         flags_ff   <= flags_in;
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_data = rsp_ff;

endmodule

// File: rtl/mouse_packet_cursor_tracker_core.sv
// Mouse packet cursor tracker: three-byte packets in, one result word out.
// Processing: once a kept packet's third byte is accepted, the shared remainder unit
// reduces the X movement, then the Y movement, before the commit state registers the
// result; a dropped packet goes straight to the commit state. Bytes are taken only in
// the collect state; the third byte also waits while the last result is unread.
// Sync reset: cursor at column 40, row 12, no buttons held, sensitivity 3.
module mouse_packet_cursor_tracker_core
   import mpct_pkg::*;
#(
   parameter int SCREEN_COLUMNS = DEF_SCREEN_COLUMNS,
   parameter int SCREEN_ROWS    = DEF_SCREEN_ROWS
) (
   input  logic         clock,
   input  logic         reset,
   mpct_chan_if.sink    req_if,
   mpct_chan_if.source  rsp_if,
   mpct_chan_if.sink    csr_if
);

   seq_state_type     state_ff, state_in;
   logic [1:0]        byte_pos_ff, byte_pos_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [BYTE_W-1:0] sensitivity_ff, sensitivity_in;
   logic [BYTE_W-1:0] head_ff, move_x_ff, move_y_ff, dx_ff, dy_ff;

   logic              req_ready;
   logic              req_fire;
   logic              head_ovf;
   logic              last_byte;
   mod_req_type       mod_req;
   mod_rsp_type       mod_rsp;
   upd_type           upd;
   rsp_payload_type   rsp_data;
   req_payload_type   req_word;
   csr_payload_type   csr_word;

   assign req_word  = req_if.payload;
   assign csr_word  = csr_if.payload;
   assign req_fire  = req_if.valid && req_ready;
   assign last_byte = byte_pos_ff == PKT_LAST_BYTE;
   assign head_ovf  = head_ff[HEAD_Y_OVF] | head_ff[HEAD_X_OVF];

   always_comb begin
      state_in         = state_ff;
      req_ready        = 1'b0;
      mod_req.start    = 1'b0;
      mod_req.dividend = move_x_ff;
      upd.commit       = 1'b0;
      upd.head         = head_ff;
      upd.dx           = dx_ff;
      upd.dy           = dy_ff;
      unique case (state_ff)
         ST_COLLECT: begin
            // hold off the closing byte while the last result is unread
            req_ready = !(last_byte && rsp_valid_ff);
            if (req_fire && last_byte) begin
               if (head_ovf) begin
                  state_in = ST_COMMIT;
               end else begin
                  mod_req.start = 1'b1;
                  state_in      = ST_MOD_X;
               end
            end
         end
         ST_MOD_X: begin
            mod_req.dividend = move_y_ff;
            if (mod_rsp.done) begin
               mod_req.start = 1'b1;
               state_in      = ST_MOD_Y;
            end
         end
         ST_MOD_Y: begin
            if (mod_rsp.done) begin
               state_in = ST_COMMIT;
            end
         end
         ST_COMMIT: begin
            upd.commit = 1'b1;
            state_in   = ST_COLLECT;
         end
         default: begin
            state_in = ST_COLLECT;
         end
      endcase
   end

   always_comb begin
      byte_pos_in = byte_pos_ff;
      if (req_fire) begin
         byte_pos_in = last_byte ? PKT_HEAD_BYTE : byte_pos_ff + 2'd1;
      end
      rsp_valid_in = rsp_valid_ff;
      if (upd.commit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end
      sensitivity_in = sensitivity_ff;
      if (csr_if.valid) begin
         sensitivity_in = csr_word.sensitivity;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_COLLECT;
         byte_pos_ff    <= PKT_HEAD_BYTE;
         rsp_valid_ff   <= 1'b0;
         sensitivity_ff <= SENSITIVITY_RESET;
      end else begin
         state_ff       <= state_in;
         byte_pos_ff    <= byte_pos_in;
         rsp_valid_ff   <= rsp_valid_in;
         sensitivity_ff <= sensitivity_in;
      end
   end

   // packet bytes and reduced movement
   always_ff @(posedge clock) begin
      if (req_fire) begin
         case (byte_pos_ff)
            PKT_HEAD_BYTE: head_ff   <= req_word.data_byte;
            PKT_X_BYTE:    move_x_ff <= req_word.data_byte;
            default:       move_y_ff <= req_word.data_byte;
         endcase
      end
      if (state_ff == ST_MOD_X && mod_rsp.done) begin
         dx_ff <= mod_rsp.remainder;
      end
      if (state_ff == ST_MOD_Y && mod_rsp.done) begin
         dy_ff <= mod_rsp.remainder;
      end
   end

   mpct_mod_unit u_mod (
      .clock   (clock),
      .reset   (reset),
      .mod_req (mod_req),
      .divisor (sensitivity_ff),
      .mod_rsp (mod_rsp)
   );

   mpct_cursor #(
      .SCREEN_COLUMNS (SCREEN_COLUMNS),
      .SCREEN_ROWS    (SCREEN_ROWS)
   ) u_cursor (
      .clock    (clock),
      .reset    (reset),
      .upd      (upd),
      .rsp_data (rsp_data)
   );

   assign req_if.ready   = req_ready;
   assign csr_if.ready   = 1'b1;
   assign rsp_if.valid   = rsp_valid_ff;
   assign rsp_if.payload = rsp_data;

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      upd.commit |-> !rsp_valid_ff)
      else $error("result word overwritten before it was taken");

   a_busy_not_ready: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_COLLECT) |-> !req_if.ready)
      else $error("byte accepted while a packet is in work");

   a_done_in_mod: assert property (@(posedge clock) disable iff (reset)
      mod_rsp.done |-> (state_ff == ST_MOD_X || state_ff == ST_MOD_Y))
      else $error("remainder done outside a reduce state");

   a_last_byte_leaves: assert property (@(posedge clock) disable iff (reset)
      (req_fire && last_byte) |=> (state_ff != ST_COLLECT && byte_pos_ff == PKT_HEAD_BYTE))
      else $error("closing byte did not start packet processing");

endmodule
